@@ rtl/sto_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sto_pkg: shared types and codes for the slot table
// Request codes, the stored entry layout and the sequencer states.
// ----------------------------------------------------------------------------
package sto_pkg;

  localparam logic REQ_SPAWN   = 1'b0;
  localparam logic REQ_DESPAWN = 1'b1;

  localparam int unsigned COORD_W = 8;
  localparam int unsigned KIND_W  = 8;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned SLOT_W  = 4;

  typedef struct packed {
    logic [TIME_W-1:0]  birth;
    logic [KIND_W-1:0]  kind;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_COMMIT = 3'b100
  } state_t;

endpackage

`default_nettype wire

@@ rtl/sto_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sto_if: request and response channels of the slot table
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface sto_req_if
  import sto_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [TIME_W-1:0]  now_ms;
  logic [COORD_W-1:0] pos_x;
  logic [COORD_W-1:0] pos_y;
  logic [KIND_W-1:0]  item_kind;

  modport source (output valid, req_type, now_ms, pos_x, pos_y, item_kind, input ready);
  modport sink   (input valid, req_type, now_ms, pos_x, pos_y, item_kind, output ready);
endinterface

interface sto_rsp_if
  import sto_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] slot_used;
  logic              evicted;
  logic [SLOT_W-1:0] evicted_slot;
  logic              success;

  modport source (output valid, slot_used, evicted, evicted_slot, success, input ready);
  modport sink   (input valid, slot_used, evicted, evicted_slot, success, output ready);
endinterface

`default_nettype wire

@@ rtl/slot_table_oldest_eviction.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// slot_table_oldest_eviction: slot allocator with oldest-entry eviction
// Spawn fills the lowest free slot or replaces the oldest entry; despawn
// frees the oldest entry.
// ----------------------------------------------------------------------------
// For each request the sequencer walks the entry memory one slot per
// cycle, and a single 32-bit comparator checks each birth time against the
// oldest seen so far while the lowest free slot is noted on the same pass.
// The next request can transfer once the sequencer returns to idle after
// the commit. A request is taken only while the sequencer is idle; a
// response waiting in the output register does not block the next request,
// but the following commit waits until it is taken. Valid marks clear at
// reset, so the block is ready right after reset.
module slot_table_oldest_eviction
  import sto_pkg::*;
#(
  parameter int unsigned SLOTS = 16
) (
  input wire logic clk,
  input wire logic rst,
  sto_req_if.sink  req,
  sto_rsp_if.source rsp
);

  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);
  localparam int unsigned ENT_W = $bits(entry_t);

  state_t             state;
  logic [SLOTS-1:0]   slot_valid;
  logic [CNT_W-1:0]   cnt;
  logic               chk_vld;
  logic [IDX_W-1:0]   chk_idx;
  logic               chk_used;

  logic               have_free;
  logic [IDX_W-1:0]   free_idx;
  logic               have_old;
  logic [IDX_W-1:0]   best_idx;
  logic [TIME_W-1:0]  best_time;

  logic               op;
  entry_t             new_entry;
  entry_t             rd_entry;

  logic               rsp_vld;
  logic [SLOT_W-1:0]  rsp_slot;
  logic               rsp_ev;
  logic [SLOT_W-1:0]  rsp_ev_slot;
  logic               rsp_ok;

  logic               scan_issue;
  logic               can_commit;
  logic [IDX_W-1:0]   target;
  logic               ram_wr;
  logic               older;

  assign scan_issue = (state == ST_SCAN) && (cnt != CNT_W'(SLOTS));
  assign can_commit = !rsp_vld || rsp.ready;
  assign target     = (op == REQ_SPAWN && have_free) ? free_idx : best_idx;
  assign ram_wr     = (state == ST_COMMIT) && can_commit && (op == REQ_SPAWN);
  assign older      = !have_old || (rd_entry.birth < best_time);

  assign req.ready        = (state == ST_IDLE);
  assign rsp.valid        = rsp_vld;
  assign rsp.slot_used    = rsp_slot;
  assign rsp.evicted      = rsp_ev;
  assign rsp.evicted_slot = rsp_ev_slot;
  assign rsp.success      = rsp_ok;

  sto_ram #(
    .WIDTH (ENT_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr),
    .wr_addr (target),
    .wr_data (new_entry),
    .rd_en   (scan_issue),
    .rd_addr (cnt[IDX_W-1:0]),
    .rd_data (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      slot_valid <= '0;
      chk_vld    <= 1'b0;
      rsp_vld    <= 1'b0;
    end else begin
      // in commit a taken response is replaced by the new one below
      if (rsp_vld && rsp.ready && (state != ST_COMMIT)) begin
        rsp_vld <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req.valid) begin
            op              <= req.req_type;
            new_entry.birth <= req.now_ms;
            new_entry.kind  <= req.item_kind;
            new_entry.y     <= req.pos_y;
            new_entry.x     <= req.pos_x;
            cnt             <= '0;
            chk_vld         <= 1'b0;
            have_free       <= 1'b0;
            have_old        <= 1'b0;
            state           <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          chk_vld <= scan_issue;
          if (scan_issue) begin
            cnt      <= cnt + CNT_W'(1);
            chk_idx  <= cnt[IDX_W-1:0];
            chk_used <= slot_valid[cnt[IDX_W-1:0]];
          end
          // read data for chk_idx arrives this cycle
          if (chk_vld) begin
            if (chk_used) begin
              if (older) begin
                have_old  <= 1'b1;
                best_idx  <= chk_idx;
                best_time <= rd_entry.birth;
              end
            end else if (!have_free) begin
              have_free <= 1'b1;
              free_idx  <= chk_idx;
            end
          end
          if (!scan_issue && !chk_vld) begin
            state <= ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          if (can_commit) begin
            rsp_vld <= 1'b1;
            if (op == REQ_SPAWN) begin
              slot_valid[target] <= 1'b1;
              rsp_slot    <= SLOT_W'(target);
              rsp_ev      <= !have_free;
              rsp_ev_slot <= have_free ? '0 : SLOT_W'(best_idx);
              rsp_ok      <= 1'b1;
            end else begin
              if (have_old) begin
                slot_valid[best_idx] <= 1'b0;
              end
              rsp_slot    <= have_old ? SLOT_W'(best_idx) : '0;
              rsp_ev      <= 1'b0;
              rsp_ev_slot <= '0;
              rsp_ok      <= have_old;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // a failed request is a despawn on an empty table and reports nothing else
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_vld && !rsp_ok |-> !rsp_ev && rsp_slot == '0 && rsp_ev_slot == '0)
    else $error("failed response carries slot data");

  // an eviction reuses the evicted slot
  a_evict_slot: assert property (@(posedge clk) disable iff (rst)
    rsp_vld && rsp_ev |-> rsp_slot == rsp_ev_slot && rsp_ok)
    else $error("evicted slot differs from written slot");

  // eviction only happens when every slot is occupied
  a_evict_full: assert property (@(posedge clk) disable iff (rst)
    state == ST_COMMIT && op == REQ_SPAWN && !have_free |-> &slot_valid)
    else $error("eviction with a free slot present");

  // a committed spawn leaves its slot occupied
  a_spawn_valid: assert property (@(posedge clk) disable iff (rst)
    ram_wr |=> slot_valid[$past(target)])
    else $error("spawned slot not marked valid");

  // a full table always yields an oldest entry
  a_full_oldest: assert property (@(posedge clk) disable iff (rst)
    state == ST_COMMIT && (&slot_valid) |-> have_old)
    else $error("full table scan found no oldest entry");
`endif

endmodule

`default_nettype wire

@@ rtl/sto_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sto_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sto_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire
